// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Needs clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define R2E_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("r2e same-cycle check failed");
// next-cycle implication
`define R2E_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("r2e next-cycle check failed");
`endif

// ----- hw/rtl/r2e_pkg.sv -----
// Shared types, constants and tables for the rotation-to-Euler core.
// No dependencies.
package r2e_pkg;

  localparam int ZW = 34;                       // CORDIC angle width, 30 fraction bits
  localparam logic signed [ZW-1:0] PI_A30 = 34'sd3373259426;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic [4:0] NEG = 5'h10;

  typedef enum logic [1:0] {
    LOCK_NONE = 2'd0,
    LOCK_LOW  = 2'd1,
    LOCK_HIGH = 2'd2,
    LOCK_BAD  = 2'd3
  } lock_t;

  typedef struct packed {
    logic       valid_seq;
    logic [3:0] key;
    logic       proper;
    logic       key_neg;
    logic [4:0] ay;
    logic [4:0] ax;
    logic [4:0] gy;
    logic [4:0] gx;
    logic [4:0] ly;
    logic [4:0] lx;
  } seq_desc_t;

  // item carried from the input stage through the root pipeline
  typedef struct packed {
    logic signed [16:0] key;
    logic signed [16:0] ay;
    logic signed [16:0] ax;
    logic signed [16:0] gy;
    logic signed [16:0] gx;
    lock_t              lock;
    logic               proper;
    logic               key_neg;
    logic signed [15:0] beta_fix;
  } stage_a_t;

  // what the output stage still needs
  typedef struct packed {
    lock_t              lock;
    logic signed [15:0] beta_fix;
  } stage_b_t;

  function automatic seq_desc_t seq_lookup(input logic [3:0] sel);
    seq_desc_t d;
    d = '0;
    case (sel)
      4'd0:  d = '{1'b1, 4'd8, 1'b1, 1'b0, 5'd2, 5'd5 | NEG, 5'd6, 5'd7, 5'd1 | NEG, 5'd0};
      4'd1:  d = '{1'b1, 4'd0, 1'b1, 1'b0, 5'd3, 5'd6 | NEG, 5'd1, 5'd2, 5'd5 | NEG, 5'd4};
      4'd2:  d = '{1'b1, 4'd4, 1'b1, 1'b0, 5'd7, 5'd1 | NEG, 5'd5, 5'd3, 5'd6 | NEG, 5'd8};
      4'd3:  d = '{1'b1, 4'd8, 1'b1, 1'b0, 5'd5, 5'd2, 5'd7, 5'd6 | NEG, 5'd3, 5'd4};
      4'd4:  d = '{1'b1, 4'd0, 1'b1, 1'b0, 5'd6, 5'd3, 5'd2, 5'd1 | NEG, 5'd7, 5'd8};
      4'd5:  d = '{1'b1, 4'd4, 1'b1, 1'b0, 5'd1, 5'd7, 5'd3, 5'd5 | NEG, 5'd2, 5'd0};
      4'd6:  d = '{1'b1, 4'd2, 1'b0, 1'b0, 5'd5 | NEG, 5'd8, 5'd1 | NEG, 5'd0, 5'd3, 5'd4};
      4'd7:  d = '{1'b1, 4'd3, 1'b0, 1'b0, 5'd6 | NEG, 5'd0, 5'd5 | NEG, 5'd4, 5'd7, 5'd8};
      4'd8:  d = '{1'b1, 4'd7, 1'b0, 1'b0, 5'd1 | NEG, 5'd4, 5'd6 | NEG, 5'd8, 5'd2, 5'd0};
      4'd9:  d = '{1'b1, 4'd1, 1'b0, 1'b1, 5'd7, 5'd4, 5'd2, 5'd0, 5'd6 | NEG, 5'd8};
      4'd10: d = '{1'b1, 4'd6, 1'b0, 1'b1, 5'd3, 5'd0, 5'd7, 5'd8, 5'd5 | NEG, 5'd4};
      4'd11: d = '{1'b1, 4'd5, 1'b0, 1'b1, 5'd2, 5'd8, 5'd3, 5'd4, 5'd1 | NEG, 5'd0};
      default: d = '0;
    endcase
    return d;
  endfunction

  // atan(2^-i) with 30 fraction bits
  function automatic logic [31:0] atan_lut(input int i);
    logic [31:0] v;
    v = 32'h0;
    case (i)
      0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
      18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
      21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
      24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
      27: v = 32'h00000007; 28: v = 32'h00000003; 29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/r2e_isqrt.sv -----
// Pipelined floor square root of one - key*key, one root bit per stage.
// Uses nothing from the package.
module r2e_isqrt #(
  parameter int EFB = 14
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [16:0]  key,
  output logic [EFB:0]        root
);
  localparam int R  = EFB + 1;
  localparam int SW = 2 * R;
  localparam int PW = (SW > 34) ? SW : 34;

  logic signed [33:0] key_e;
  logic signed [33:0] kk_c;
  logic [33:0]        kk;
  logic [PW-1:0]      diff;

  logic [SW-1:0] rem [R+1];
  logic [R-1:0]  q   [R+1];

  assign key_e = 34'(key);
  assign kk_c  = key_e * key_e;

  always_ff @(posedge clk) begin
    if (en) begin
      kk <= kk_c;
    end
  end

  assign diff   = (PW'(1) << (2 * EFB)) - PW'(kk);
  assign rem[0] = diff[SW-1:0];
  assign q[0]   = '0;

  for (genvar i = 0; i < R; i++) begin : g_step
    localparam int B = R - 1 - i;
    logic [SW-1:0] trial;
    assign trial = (SW'(q[i]) << (B + 1)) + (SW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[i] >= trial) begin
          rem[i+1] <= rem[i] - trial;
          q[i+1]   <= q[i] | (R'(1) << B);
        end else begin
          rem[i+1] <= rem[i];
          q[i+1]   <= q[i];
        end
      end
    end
  end

  assign root = q[R];
endmodule

// ----- hw/rtl/r2e_cordic.sv -----
// Pipelined CORDIC vectoring unit: atan2(y, x) to Q3.13, clamped to +-pi.
// Uses r2e_pkg for the angle table and pi.
module r2e_cordic #(
  parameter int IW = 17,
  parameter int SH = 16,
  parameter int N  = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [IW-1:0] y,
  input  logic signed [IW-1:0] x,
  output logic signed [15:0]   angle
);
  localparam int XW = IW + SH + 3;
  localparam int ZW = r2e_pkg::ZW;
  localparam int QW = ZW - 17;

  logic signed [XW-1:0] xr [N+1];
  logic signed [XW-1:0] yr [N+1];
  logic signed [ZW-1:0] zr [N+1];
  logic                 zero [N+1];

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  assign xs = XW'(x) <<< SH;
  assign ys = XW'(y) <<< SH;

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x == '0) && (y == '0);
      if (xs[XW-1]) begin
        xr[0] <= -xs;
        yr[0] <= -ys;
        zr[0] <= ys[XW-1] ? -r2e_pkg::PI_A30 : r2e_pkg::PI_A30;
      end else begin
        xr[0] <= xs;
        yr[0] <= ys;
        zr[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = ZW'({1'b0, r2e_pkg::atan_lut(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (!yr[i][XW-1]) begin
          xr[i+1] <= xr[i] + (yr[i] >>> i);
          yr[i+1] <= yr[i] - (xr[i] >>> i);
          zr[i+1] <= zr[i] + ATAN;
        end else begin
          xr[i+1] <= xr[i] - (yr[i] >>> i);
          yr[i+1] <= yr[i] + (xr[i] >>> i);
          zr[i+1] <= zr[i] - ATAN;
        end
      end
    end
  end

  logic signed [ZW-1:0] zrnd;
  logic signed [QW-1:0] zq;
  logic signed [QW-1:0] pi_q;

  assign zrnd = zr[N] + (ZW'(1) <<< 16);
  assign zq   = zrnd[ZW-1:17];
  assign pi_q = QW'(r2e_pkg::PI_Q13);

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero[N]) begin
        angle <= '0;
      end else if (zq > pi_q) begin
        angle <= r2e_pkg::PI_Q13;
      end else if (zq < -pi_q) begin
        angle <= -r2e_pkg::PI_Q13;
      end else begin
        angle <= zq[15:0];
      end
    end
  end
endmodule

// ----- hw/rtl/rotation_to_euler_angles_core.sv -----
// Channel   Handshake                 Payload
// item      item_valid / item_stall   euler_sequence, rot_00 .. rot_22
// result    result_valid / result_stall  angle_alpha/beta/gamma, lock_state
//
// One item per cycle while no result is stalled. Path: input stage, root
// pipeline (one bit per stage), three parallel CORDIC pipelines (one
// micro-rotation per stage), output stage.
// rst clears only the valid bits. A stalled result freezes the whole pipeline;
// item_stall follows result_stall while a result is held.
// Uses r2e_pkg, r2e_isqrt, r2e_cordic and assert_macros.svh.
`include "assert_macros.svh"
module rotation_to_euler_angles_core #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ENTRY_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [3:0]         euler_sequence,
  input  logic signed [15:0] rot_00,
  input  logic signed [15:0] rot_01,
  input  logic signed [15:0] rot_02,
  input  logic signed [15:0] rot_10,
  input  logic signed [15:0] rot_11,
  input  logic signed [15:0] rot_12,
  input  logic signed [15:0] rot_20,
  input  logic signed [15:0] rot_21,
  input  logic signed [15:0] rot_22,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [15:0] angle_alpha,
  output logic signed [15:0] angle_beta,
  output logic signed [15:0] angle_gamma,
  output logic [1:0]         lock_state
);
  localparam int EFB = ENTRY_FRAC_BITS;
  localparam int N   = CORDIC_STAGES;
  localparam int LSQ = EFB + 2;                 // root pipeline latency
  localparam int OW  = (EFB + 2 > 17) ? EFB + 2 : 17;
  localparam int SH  = 30 - EFB;
  localparam logic signed [31:0] ONE32 = 32'sd1 <<< EFB;

  logic en;
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  // ---- input decode ----
  logic [8:0][15:0]     m;
  r2e_pkg::seq_desc_t   desc;
  r2e_pkg::stage_a_t    a_in;
  logic signed [31:0]   key32;

  function automatic logic signed [16:0] pick(input logic [8:0][15:0] mm,
                                              input logic [4:0] code);
    logic signed [16:0] v;
    v = 17'(signed'(mm[code[3:0]]));
    return code[4] ? -v : v;
  endfunction

  assign m = {rot_22, rot_21, rot_20, rot_12, rot_11, rot_10, rot_02, rot_01, rot_00};

  always_comb begin
    desc         = r2e_pkg::seq_lookup(euler_sequence);
    a_in.key     = 17'(signed'(m[desc.key]));
    key32        = 32'(a_in.key);
    a_in.proper  = desc.proper;
    a_in.key_neg = desc.key_neg;
    a_in.gy      = pick(m, desc.gy);
    a_in.gx      = pick(m, desc.gx);
    a_in.ay      = pick(m, desc.ay);
    a_in.ax      = pick(m, desc.ax);
    a_in.beta_fix = '0;
    if (!desc.valid_seq) begin
      a_in.lock = r2e_pkg::LOCK_BAD;
    end else if (key32 >= ONE32) begin
      a_in.lock = r2e_pkg::LOCK_HIGH;
      a_in.ay   = pick(m, desc.ly);
      a_in.ax   = pick(m, desc.lx);
      if (!desc.proper) begin
        a_in.beta_fix = desc.key_neg ? -r2e_pkg::HALF_PI_Q13 : r2e_pkg::HALF_PI_Q13;
      end
    end else if (key32 <= -ONE32) begin
      a_in.lock = r2e_pkg::LOCK_LOW;
      a_in.ay   = pick(m, desc.ly);
      a_in.ax   = pick(m, desc.lx);
      if (desc.proper) begin
        a_in.beta_fix = r2e_pkg::PI_Q13;
      end else begin
        a_in.beta_fix = desc.key_neg ? r2e_pkg::HALF_PI_Q13 : -r2e_pkg::HALF_PI_Q13;
      end
    end else begin
      a_in.lock = r2e_pkg::LOCK_NONE;
    end
  end

  // ---- stage A: input register plus delay alongside the root pipeline ----
  r2e_pkg::stage_a_t pa [LSQ+1];
  logic [LSQ:0]      va;

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= a_in;
      for (int j = 1; j <= LSQ; j++) begin
        pa[j] <= pa[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= '0;
    end else if (en) begin
      va <= {va[LSQ-1:0], item_valid};
    end
  end

  logic [EFB:0] root;

  r2e_isqrt #(.EFB(EFB)) u_isqrt (
    .clk  (clk),
    .en   (en),
    .key  (pa[0].key),
    .root (root)
  );

  // ---- CORDIC operands ----
  r2e_pkg::stage_a_t pl;
  logic signed [OW-1:0] key_o;
  logic signed [OW-1:0] root_o;
  logic signed [OW-1:0] by;
  logic signed [OW-1:0] bx;

  assign pl     = pa[LSQ];
  assign key_o  = OW'(pl.key);
  assign root_o = signed'(OW'(root));

  always_comb begin
    if (pl.proper) begin
      by = root_o;
      bx = key_o;
    end else begin
      by = pl.key_neg ? -key_o : key_o;
      bx = root_o;
    end
  end

  logic signed [15:0] ca;
  logic signed [15:0] cb;
  logic signed [15:0] cg;

  r2e_cordic #(.IW(OW), .SH(SH), .N(N)) u_cordic_a (
    .clk (clk), .en (en), .y (OW'(pl.ay)), .x (OW'(pl.ax)), .angle (ca)
  );
  r2e_cordic #(.IW(OW), .SH(SH), .N(N)) u_cordic_b (
    .clk (clk), .en (en), .y (by), .x (bx), .angle (cb)
  );
  r2e_cordic #(.IW(OW), .SH(SH), .N(N)) u_cordic_g (
    .clk (clk), .en (en), .y (OW'(pl.gy)), .x (OW'(pl.gx)), .angle (cg)
  );

  // ---- stage B: side data alongside the CORDIC pipelines ----
  r2e_pkg::stage_b_t pb [N+2];
  logic [N+1:0]      vb;

  always_ff @(posedge clk) begin
    if (en) begin
      pb[0] <= '{pl.lock, pl.beta_fix};
      for (int j = 1; j <= N + 1; j++) begin
        pb[j] <= pb[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (en) begin
      vb <= {vb[N:0], va[LSQ]};
    end
  end

  // ---- output register ----
  r2e_pkg::stage_b_t pe;
  assign pe = pb[N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vb[N+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lock_state <= pe.lock;
      case (pe.lock)
        r2e_pkg::LOCK_NONE: begin
          angle_alpha <= ca;
          angle_beta  <= cb;
          angle_gamma <= cg;
        end
        r2e_pkg::LOCK_LOW: begin
          angle_alpha <= -ca;
          angle_beta  <= pe.beta_fix;
          angle_gamma <= '0;
        end
        r2e_pkg::LOCK_HIGH: begin
          angle_alpha <= ca;
          angle_beta  <= pe.beta_fix;
          angle_gamma <= '0;
        end
        default: begin
          angle_alpha <= '0;
          angle_beta  <= '0;
          angle_gamma <= '0;
        end
      endcase
    end
  end

  // ---- checks ----
  `R2E_ASSERT_IMP(a_bad_seq_zero, result_valid && lock_state == r2e_pkg::LOCK_BAD,
                  angle_alpha == '0 && angle_beta == '0 && angle_gamma == '0)
  `R2E_ASSERT_IMP(a_lock_gamma_zero, result_valid && lock_state != r2e_pkg::LOCK_NONE,
                  angle_gamma == '0)
  `R2E_ASSERT_NXT(a_accept_enters, item_valid && !item_stall, va[0])

endmodule
